@@ rtl/ink_drop_vertex_displace_top_defines.svh @@
// assertion macros for the ink drop vertex displacement block
// used by ink_drop_vertex_displace_top.sv, no other dependencies
`ifndef INK_DROP_VERTEX_DISPLACE_TOP_DEFINES_SVH
`define INK_DROP_VERTEX_DISPLACE_TOP_DEFINES_SVH
`ifndef SYNTH
`define IDVD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IDVD_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IDVD_ASSERT(lbl, clk, rst_n, prop, msg)
`define IDVD_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/idvd_pkg.sv @@
// shared widths, limits and register codes for the ink drop displacement block
// no dependencies
`default_nettype none

package idvd_pkg;

    localparam int COORD_W  = 18;
    localparam int RAD_W    = 12;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int AD_W     = 18;
    localparam int SQ_W     = 2 * AD_W;
    localparam int RR_W     = 2 * RAD_W;
    localparam int M_W      = SQ_W + 1;
    localparam int S_W      = M_W + 1;
    localparam int SLO_W    = 19;
    localparam int SHI_W    = S_W - SLO_W;
    localparam int P_W      = AD_W + S_W;
    localparam int PC0_W    = 19;
    localparam int PC1_W    = 19;
    localparam int PC2_W    = P_W - PC0_W - PC1_W;
    localparam int Q_W      = 19;
    localparam int A_W      = 80;
    localparam int SUM_W    = Q_W + 2;
    localparam int LANE_LAT = 4 + Q_W;
    localparam int TDATA_W  = 40;
    localparam int TUSER_W  = 2;
    localparam int ADDR_W   = 4;
    localparam int PDATA_W  = 32;

    localparam logic signed [SUM_W-1:0] COORD_MAX = SUM_W'(131071);
    localparam logic signed [SUM_W-1:0] COORD_MIN = -SUM_W'(131072);

    typedef enum logic [1:0] {
        REG_CENTER_X    = 2'd0,
        REG_CENTER_Y    = 2'd1,
        REG_DROP_RADIUS = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

@@ rtl/idvd_lane.sv @@
// one coordinate lane: builds 4*ad^2*s in partial products, then
// finds the rounded radial offset one result bit per stage; uses idvd_pkg
`default_nettype none

module idvd_lane
    import idvd_pkg::*;
(
    input  logic            clk,
    input  logic            en,
    input  logic [AD_W-1:0] ad,
    input  logic [S_W-1:0]  s,
    input  logic [M_W-1:0]  m,
    output logic [Q_W-1:0]  q
);

    logic [AD_W-1:0]  ad4_reg, ad5_reg;
    logic [M_W-1:0]   m4_reg, m5_reg, m6_reg;
    logic [AD_W+SLO_W-1:0] plo_reg;
    logic [AD_W+SHI_W-1:0] phi_reg;
    logic [P_W-1:0]   p_reg;
    logic [AD_W+PC0_W-1:0] pp0_reg;
    logic [AD_W+PC1_W-1:0] pp1_reg;
    logic [AD_W+PC2_W-1:0] pp2_reg;

    logic [A_W-1:0]        sum_next;
    logic signed [A_W-1:0] a_next, b_next;

    logic signed [A_W-1:0] a_reg  [Q_W];
    logic signed [A_W-1:0] b_reg  [Q_W];
    logic [M_W-1:0]        mr_reg [Q_W];
    logic [Q_W-1:0]        q_reg  [Q_W+1];

    // partial products of ad*s
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ad4_reg <= ad;
            m4_reg  <= m;
            plo_reg <= (AD_W+SLO_W)'(ad) * (AD_W+SLO_W)'(s[SLO_W-1:0]);
            phi_reg <= (AD_W+SHI_W)'(ad) * (AD_W+SHI_W)'(s[S_W-1:SLO_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ad5_reg <= ad4_reg;
            m5_reg  <= m4_reg;
            p_reg   <= P_W'(plo_reg) + (P_W'(phi_reg) << SLO_W);
        end
    end

    // partial products of ad*(ad*s)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m6_reg  <= m5_reg;
            pp0_reg <= (AD_W+PC0_W)'(ad5_reg) * (AD_W+PC0_W)'(p_reg[PC0_W-1:0]);
            pp1_reg <= (AD_W+PC1_W)'(ad5_reg)
                       * (AD_W+PC1_W)'(p_reg[PC0_W+PC1_W-1:PC0_W]);
            pp2_reg <= (AD_W+PC2_W)'(ad5_reg) * (AD_W+PC2_W)'(p_reg[P_W-1:PC0_W+PC1_W]);
        end
    end

    // remainder start: 4*ad^2*s - m, cross term -m
    always_comb
    begin
        sum_next = (A_W'(pp0_reg) + (A_W'(pp1_reg) << PC0_W)
                   + (A_W'(pp2_reg) << (PC0_W + PC1_W))) << 2;
        a_next   = $signed(sum_next - A_W'(m6_reg));
        b_next   = -$signed(A_W'(m6_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0]  <= a_next;
            b_reg[0]  <= b_next;
            mr_reg[0] <= m6_reg;
            q_reg[0]  <= '0;
        end
    end

    // one result bit per stage, msb first
    for (genvar i = 0; i < Q_W; i++)
    begin : g_step
        localparam int K = Q_W - 1 - i;
        logic signed [A_W-1:0] m_ext;
        logic signed [A_W-1:0] trial;
        logic                  take;

        always_comb
        begin
            m_ext = $signed(A_W'(mr_reg[i]));
            trial = a_reg[i] - (b_reg[i] <<< (K + 2)) - (m_ext <<< (2 * K + 2));
            take  = ~trial[A_W-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[i+1] <= take ? (q_reg[i] | (Q_W'(1) << K)) : q_reg[i];
            end
        end

        if (i < Q_W - 1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_reg[i+1]  <= take ? trial : a_reg[i];
                    b_reg[i+1]  <= take ? (b_reg[i] + (m_ext <<< (K + 1))) : b_reg[i];
                    mr_reg[i+1] <= mr_reg[i];
                end
            end
        end
    end

    assign q = q_reg[Q_W];

endmodule

`default_nettype wire

@@ rtl/ink_drop_vertex_displace_top.sv @@
// Ink drop vertex displacement. Each vertex (x, y) on s_tdata is pushed
// radially away from the drop center to C + (P-C)*sqrt(1 + r^2/|P-C|^2),
// rounded to the nearest Q13.4 step and saturated.
// Channels: s_* takes vertices (tdata: vertex_x, vertex_y), m_* gives the
// moved vertex (tdata: moved_x, moved_y; tuser: degenerate, clipped).
// Center and radius sit in APB registers at 0x0, 0x4, 0x8; write them only
// while no transfer is in flight.
// Throughput: one vertex per cycle when the receiver does not stall; the
// offset is resolved one bit per stage over 19 stages after a four stage
// product chain.
// Reset clears all valid bits and the registers; the pipeline comes up empty.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
// Uses idvd_pkg, idvd_lane and the assertion macro header.
`default_nettype none
`include "ink_drop_vertex_displace_top_defines.svh"

module ink_drop_vertex_displace_top
    import idvd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // vertex_x[17:0], vertex_y[35:18], zero
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // moved_x[17:0], moved_y[35:18], zero
    output logic [TUSER_W-1:0] m_tuser    // degenerate[0], clipped[1]
);

    logic [COORD_W-1:0] center_x_reg, center_y_reg;
    logic [RAD_W-1:0]   drop_radius_reg;
    logic               en;

    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [DIFF_W-1:0] dx_next, dy_next;
    logic                     nx1_reg, ny1_reg, nx2_reg, ny2_reg, nx3_reg, ny3_reg;
    logic [AD_W-1:0]          adx1_reg, ady1_reg, adx2_reg, ady2_reg, adx3_reg, ady3_reg;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;
    logic [RR_W-1:0]          rr_reg;
    logic [M_W-1:0]           m_reg;
    logic [S_W-1:0]           s_reg;
    logic                     dg3_reg;

    logic [LANE_LAT-1:0] vld_pipe_reg, nx_pipe_reg, ny_pipe_reg, dg_pipe_reg;
    logic [Q_W-1:0]      qx, qy;

    logic signed [SUM_W-1:0] ox, oy, rx, ry;
    logic [COORD_W-1:0]      mx_next, my_next;
    logic                    clip_next;

    logic               out_vld_reg;
    logic [COORD_W-1:0] mx_reg, my_reg;
    logic               dg_out_reg, clip_out_reg;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            drop_radius_reg <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (cfg_reg_t'(paddr[ADDR_W-1:2]))
                REG_CENTER_X:    center_x_reg    <= pwdata[COORD_W-1:0];
                REG_CENTER_Y:    center_y_reg    <= pwdata[COORD_W-1:0];
                REG_DROP_RADIUS: drop_radius_reg <= pwdata[RAD_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_reg_t'(paddr[ADDR_W-1:2]))
            REG_CENTER_X:    prdata = PDATA_W'(center_x_reg);
            REG_CENTER_Y:    prdata = PDATA_W'(center_y_reg);
            REG_DROP_RADIUS: prdata = PDATA_W'(drop_radius_reg);
            default:         prdata = '0;
        endcase
    end

    // global advance
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // stage 1: difference and magnitude
    always_comb
    begin
        dx_next = DIFF_W'($signed(s_tdata[COORD_W-1:0])) - DIFF_W'($signed(center_x_reg));
        dy_next = DIFF_W'($signed(s_tdata[2*COORD_W-1:COORD_W]))
                  - DIFF_W'($signed(center_y_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            vld_pipe_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            v1_reg       <= s_tvalid && s_tready;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            vld_pipe_reg <= {vld_pipe_reg[LANE_LAT-2:0], v3_reg};
            out_vld_reg  <= vld_pipe_reg[LANE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx1_reg  <= dx_next[DIFF_W-1];
            ny1_reg  <= dy_next[DIFF_W-1];
            adx1_reg <= dx_next[DIFF_W-1] ? AD_W'(-dx_next) : AD_W'(dx_next);
            ady1_reg <= dy_next[DIFF_W-1] ? AD_W'(-dy_next) : AD_W'(dy_next);

            // stage 2: squares
            nx2_reg  <= nx1_reg;
            ny2_reg  <= ny1_reg;
            adx2_reg <= adx1_reg;
            ady2_reg <= ady1_reg;
            sqx_reg  <= SQ_W'(adx1_reg) * SQ_W'(adx1_reg);
            sqy_reg  <= SQ_W'(ady1_reg) * SQ_W'(ady1_reg);
            rr_reg   <= RR_W'(drop_radius_reg) * RR_W'(drop_radius_reg);

            // stage 3: |P-C|^2 and |P-C|^2 + r^2
            nx3_reg  <= nx2_reg;
            ny3_reg  <= ny2_reg;
            adx3_reg <= adx2_reg;
            ady3_reg <= ady2_reg;
            m_reg    <= M_W'(sqx_reg) + M_W'(sqy_reg);
            s_reg    <= S_W'(sqx_reg) + S_W'(sqy_reg) + S_W'(rr_reg);
            dg3_reg  <= (sqx_reg == '0) && (sqy_reg == '0);

            nx_pipe_reg <= {nx_pipe_reg[LANE_LAT-2:0], nx3_reg};
            ny_pipe_reg <= {ny_pipe_reg[LANE_LAT-2:0], ny3_reg};
            dg_pipe_reg <= {dg_pipe_reg[LANE_LAT-2:0], dg3_reg};
        end
    end

    idvd_lane u_lane_x
    (
        .clk (clk),
        .en  (en),
        .ad  (adx3_reg),
        .s   (s_reg),
        .m   (m_reg),
        .q   (qx)
    );

    idvd_lane u_lane_y
    (
        .clk (clk),
        .en  (en),
        .ad  (ady3_reg),
        .s   (s_reg),
        .m   (m_reg),
        .q   (qy)
    );

    // final stage: sign, recenter, saturate
    always_comb
    begin
        ox = nx_pipe_reg[LANE_LAT-1] ? -$signed(SUM_W'(qx)) : $signed(SUM_W'(qx));
        oy = ny_pipe_reg[LANE_LAT-1] ? -$signed(SUM_W'(qy)) : $signed(SUM_W'(qy));
        rx = SUM_W'($signed(center_x_reg)) + ox;
        ry = SUM_W'($signed(center_y_reg)) + oy;
        clip_next = 1'b0;
        if (rx > COORD_MAX)
        begin
            mx_next   = COORD_W'(COORD_MAX);
            clip_next = 1'b1;
        end
        else if (rx < COORD_MIN)
        begin
            mx_next   = COORD_W'(COORD_MIN);
            clip_next = 1'b1;
        end
        else
        begin
            mx_next = COORD_W'(rx);
        end
        if (ry > COORD_MAX)
        begin
            my_next   = COORD_W'(COORD_MAX);
            clip_next = 1'b1;
        end
        else if (ry < COORD_MIN)
        begin
            my_next   = COORD_W'(COORD_MIN);
            clip_next = 1'b1;
        end
        else
        begin
            my_next = COORD_W'(ry);
        end
        // vertex on the center passes through unchanged
        if (dg_pipe_reg[LANE_LAT-1])
        begin
            mx_next   = center_x_reg;
            my_next   = center_y_reg;
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg       <= mx_next;
            my_reg       <= my_next;
            dg_out_reg   <= dg_pipe_reg[LANE_LAT-1];
            clip_out_reg <= clip_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {(TDATA_W - 2 * COORD_W)'(0), my_reg, mx_reg};
    assign m_tuser  = {clip_out_reg, dg_out_reg};

    `IDVD_ASSERT(a_degen_no_clip, clk, rst_n, (m_tvalid && m_tuser[0]) |-> !m_tuser[1], "degenerate vertex flagged clipped")
    `IDVD_ASSERT(a_clip_at_bound, clk, rst_n, (m_tvalid && m_tuser[1]) |-> (m_tdata[17:0] == 18'h1ffff || m_tdata[17:0] == 18'h20000 || m_tdata[35:18] == 18'h1ffff || m_tdata[35:18] == 18'h20000), "clipped result not at a bound")
    `IDVD_ASSERT(a_stall_keeps_result, clk, rst_n, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped under stall")
    `IDVD_ASSERT_RST(a_reset_empty, clk, !rst_n |=> (!out_vld_reg && vld_pipe_reg == '0), "pipeline valid during reset")

endmodule

`default_nettype wire

@@ sim/ink_drop_vertex_displace_top_tb.sv @@
// self-checking testbench for ink_drop_vertex_displace_top: streams vertices under
// random and forced stalls and checks every moved vertex against a local predictor
// depends on idvd_pkg and the rtl of ink_drop_vertex_displace_top
`timescale 1ns / 100ps

module ink_drop_vertex_displace_top_tb;
    import idvd_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] moved_x;
        logic [COORD_W-1:0] moved_y;
        logic               degenerate;
        logic               clipped;
    } moved_vertex_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;      // vertex_x[17:0], vertex_y[35:18], zero
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;           // moved_x[17:0], moved_y[35:18], zero
    logic [TUSER_W-1:0] m_tuser;           // degenerate[0], clipped[1]

    moved_vertex_t        expected_moves[$];
    logic signed [17:0]   drop_cx = '0;
    logic signed [17:0]   drop_cy = '0;
    logic [RAD_W-1:0]     drop_r = '0;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   hold_cycles = 0;
    int                   error_count = 0;

    ink_drop_vertex_displace_top uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    // round(|d| * sqrt(s/m)), ties away from zero, found by bisection
    function automatic longint unsigned radial_offset(longint unsigned ad,
                                                      longint unsigned m,
                                                      longint unsigned s);
        logic [127:0]    lhs;
        logic [127:0]    rhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t;
        lo = 0;
        hi = 64'd1 << 20;
        rhs = 128'(4 * ad * ad) * 128'(s);
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            t = 2 * mid - 1;
            lhs = 128'(t * t) * 128'(m);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic longint clamp_coord(longint v, ref logic clip);
        if (v < -131072)
        begin
            clip = 1'b1;
            return -131072;
        end
        if (v > 131071)
        begin
            clip = 1'b1;
            return 131071;
        end
        return v;
    endfunction

    function automatic moved_vertex_t predict_move(logic signed [17:0] px,
                                                   logic signed [17:0] py);
        moved_vertex_t   res;
        longint          dx;
        longint          dy;
        longint          ox;
        longint          oy;
        longint unsigned adx;
        longint unsigned ady;
        longint unsigned m;
        longint unsigned s;
        logic            clip;
        clip = 1'b0;
        dx = longint'(px) - longint'(drop_cx);
        dy = longint'(py) - longint'(drop_cy);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        m = adx * adx + ady * ady;
        res = '0;
        if (m == 0)
        begin
            res.moved_x = px;
            res.moved_y = py;
            res.degenerate = 1'b1;
        end
        else
        begin
            s = m + longint'(drop_r) * longint'(drop_r);
            ox = radial_offset(adx, m, s);
            oy = radial_offset(ady, m, s);
            if (dx < 0) ox = -ox;
            if (dy < 0) oy = -oy;
            res.moved_x = 18'(clamp_coord(longint'(drop_cx) + ox, clip));
            res.moved_y = 18'(clamp_coord(longint'(drop_cy) + oy, clip));
        end
        res.clipped = clip;
        return res;
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = ADDR_W'(4 * int'(idx));
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_drop(logic signed [17:0] cx, logic signed [17:0] cy,
                            logic [RAD_W-1:0] r);
        end_burst();
        wait (expected_moves.size() == 0);
        repeat (LANE_LAT + 8) @(negedge clk);
        write_reg(REG_CENTER_X, 32'(cx));
        write_reg(REG_CENTER_Y, 32'(cy));
        write_reg(REG_DROP_RADIUS, 32'(r));
        drop_cx = cx;
        drop_cy = cy;
        drop_r = r;
    endtask

    // called and returns at a falling edge; tvalid stays high for a following item
    task automatic send_vertex(logic [17:0] x, logic [17:0] y);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {4'b0, y, x};
        do @(posedge clk); while (!s_tready);
        expected_moves.push_back(predict_move(x, y));
        @(negedge clk);
    endtask

    task automatic end_burst();
        s_tvalid = 1'b0;
    endtask

    function automatic logic [17:0] pick_coord(logic signed [17:0] c);
        case ($urandom_range(0, 3))
            0: return 18'($urandom_range(0, 262143));
            1: return 18'(longint'(c) + $urandom_range(0, 64) - 32);
            default: return 18'(longint'(c) + $urandom_range(0, 8000) - 4000);
        endcase
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send_vertex(pick_coord(drop_cx), pick_coord(drop_cy));
        end_burst();
    endtask

    task automatic test_directed();
        set_drop(18'sd0, 18'sd0, 12'd0);
        send_vertex(18'd100, -18'sd37);
        send_vertex(18'h1ffff, 18'h20000);
        send_vertex(18'd0, 18'd0);
        set_drop(18'sd40, -18'sd16, 12'd4095);
        send_vertex(18'd40, -18'sd16);
        send_vertex(18'd41, -18'sd16);
        send_vertex(18'd40, -18'sd15);
        send_vertex(18'd39, -18'sd17);
        send_vertex(18'h1ffff, 18'h1ffff);
        send_vertex(18'h20000, 18'h20000);
        send_vertex(18'h1ffff, 18'h20000);
        send_vertex(18'd1000, 18'd5000);
        set_drop(18'sh1ffff, 18'sh20000, 12'd1);
        send_vertex(18'h1ffff, 18'h20000);
        send_vertex(18'h1fffe, 18'h20001);
        send_vertex(18'h20000, 18'h1ffff);
        send_vertex(18'd0, 18'd0);
        set_drop(-18'sd5000, 18'sd3000, 12'd2048);
        send_vertex(-18'sd5000, 18'sd3000);
        send_vertex(-18'sd4990, 18'sd3000);
        send_vertex(-18'sd5000, 18'sd2000);
        send_vertex(-18'sd3000, 18'sd5000);
        end_burst();
    endtask

    task automatic test_random_idling();
        send_idle_pct = 29;
        recv_idle_pct = 64;
        set_drop(18'($urandom_range(0, 262143)), 18'($urandom_range(0, 262143)),
                 12'($urandom_range(0, 4095)));
        run_random(200);
        send_idle_pct = 64;
        recv_idle_pct = 29;
        set_drop(18'sh20000, 18'sh1ffff, 12'd4095);
        run_random(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_drop(18'($urandom_range(0, 262143)), 18'($urandom_range(0, 262143)),
                 12'($urandom_range(0, 255)));
        run_random(200);
    endtask

    task automatic test_backpressure();
        set_drop(18'sd800, -18'sd800, 12'd300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 300;
        run_random(60);
        wait (expected_moves.size() == 0);
        run_random(10);
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles = hold_cycles - 1;
            m_tready = 1'b0;
        end
        else
            m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        moved_vertex_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_moves.size() == 0)
            begin
                $error("unexpected transfer: tdata %h tuser %b", m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                want = expected_moves.pop_front();
                if (m_tdata[17:0] !== want.moved_x)
                begin
                    $error("moved_x expected %0d actual %0d",
                           $signed(want.moved_x), $signed(m_tdata[17:0]));
                    error_count++;
                end
                if (m_tdata[35:18] !== want.moved_y)
                begin
                    $error("moved_y expected %0d actual %0d",
                           $signed(want.moved_y), $signed(m_tdata[35:18]));
                    error_count++;
                end
                if (m_tuser[0] !== want.degenerate)
                begin
                    $error("degenerate expected %b actual %b", want.degenerate, m_tuser[0]);
                    error_count++;
                end
                if (m_tuser[1] !== want.clipped)
                begin
                    $error("clipped expected %b actual %b", want.clipped, m_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_idling();
        test_backpressure();
        wait (expected_moves.size() == 0);
        repeat (LANE_LAT + 20) @(posedge clk);
        if (error_count == 0 && expected_moves.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
